### rtl/core/hpe_pkg.sv
`default_nettype none

package hpe_pkg;

	localparam int unsigned ELEM_W = 32;
	localparam int unsigned POS_W  = 6;

	typedef struct packed {
		logic signed [ELEM_W-1:0] element;
		logic                     is_last;
	} in_item_t;

	typedef struct packed {
		logic signed [ELEM_W-1:0] out_element;
		logic [POS_W-1:0]         position;
		logic [POS_W-1:0]         split_index;
		logic                     overflow;
		logic                     last_out;
	} result_t;

	typedef enum logic [2:0] {
		ST_LOAD,
		ST_PIV_RD,
		ST_PIV,
		ST_LEFT_RD,
		ST_LEFT,
		ST_RIGHT,
		ST_SWAP,
		ST_EMIT
	} state_t;

endpackage

`default_nettype wire

### rtl/core/hpe_store.sv
`default_nettype none

module hpe_store #(
	parameter int unsigned DEPTH = 64,
	parameter int unsigned AW    = 6
) (
	input  wire logic                            clk,
	input  wire logic                            we,
	input  wire logic                            re,
	input  wire logic [AW-1:0]                   addr,
	input  wire logic signed [hpe_pkg::ELEM_W-1:0] wdata,
	output logic signed [hpe_pkg::ELEM_W-1:0]      rdata
);

	logic signed [hpe_pkg::ELEM_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		if (re) begin
			rdata <= mem[addr];
		end
	end

endmodule

`default_nettype wire

### rtl/core/hoare_partition_engine.sv
// channel  | signals                 | transfer
// ---------+-------------------------+-----------------------------------------
// input    | start, busy, item       | taken at a clock edge with start & !busy
// result   | strobe, result          | one result per strobe, no back-pressure
//
// Loading stores each accepted element while room remains; the item marked last starts the
// partition. The partition runs on the single-port element memory: a pivot read and capture,
// then one pointer compare per memory read, a swap as two writes and one read to restart the
// left walk after each swap. Emission streams one result per cycle, DEPTH max.
// Reset clears the fill count, overflow flag and sequencer; the memory is not cleared.
// busy stays high from the closing transaction until the read of the last result.
`default_nettype none

module hoare_partition_engine #(
	parameter int unsigned DEPTH = 64
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	output logic                  busy,
	input  wire hpe_pkg::in_item_t item,
	output logic                  strobe,
	output hpe_pkg::result_t      result
);

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	hpe_pkg::state_t state_q, state_nx;

	logic [CW-1:0] cnt_q, cnt_nx;
	logic          ovf_q;
	logic [AW-1:0] left_q, right_q, pos_q, split_q;
	logic signed [hpe_pkg::ELEM_W-1:0] pivot_q, lval_q;

	logic          valid_s1, last_s1, ovf_s1;
	logic [AW-1:0] pos_s1;

	logic          mem_we, mem_re;
	logic [AW-1:0] mem_addr;
	logic signed [hpe_pkg::ELEM_W-1:0] mem_wdata, rdata;

	logic accept, room, left_go, right_go, crossed, emit_last;

	hpe_store #(
		.DEPTH(DEPTH),
		.AW   (AW)
	) u_store (
		.clk  (clk),
		.we   (mem_we),
		.re   (mem_re),
		.addr (mem_addr),
		.wdata(mem_wdata),
		.rdata(rdata)
	);

	assign accept    = start && (state_q == hpe_pkg::ST_LOAD);
	assign room      = cnt_q < CW'(DEPTH);
	assign cnt_nx    = room ? cnt_q + CW'(1) : cnt_q;
	assign left_go   = ((CW'(left_q) + CW'(1)) < cnt_q) && (rdata < pivot_q);
	assign right_go  = (right_q != '0) && (rdata > pivot_q);
	assign crossed   = left_q >= right_q;
	assign emit_last = (CW'(pos_q) + CW'(1)) == cnt_q;

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			hpe_pkg::ST_LOAD: begin
				if (accept && item.is_last) state_nx = hpe_pkg::ST_PIV_RD;
			end
			hpe_pkg::ST_PIV_RD:  state_nx = hpe_pkg::ST_PIV;
			hpe_pkg::ST_PIV:     state_nx = hpe_pkg::ST_RIGHT;
			hpe_pkg::ST_LEFT_RD: state_nx = hpe_pkg::ST_LEFT;
			hpe_pkg::ST_LEFT: begin
				state_nx = left_go ? hpe_pkg::ST_LEFT : hpe_pkg::ST_RIGHT;
			end
			hpe_pkg::ST_RIGHT: begin
				priority if (right_go) state_nx = hpe_pkg::ST_RIGHT;
				else if (crossed)      state_nx = hpe_pkg::ST_EMIT;
				else                   state_nx = hpe_pkg::ST_SWAP;
			end
			hpe_pkg::ST_SWAP: state_nx = hpe_pkg::ST_LEFT_RD;
			hpe_pkg::ST_EMIT: begin
				if (emit_last) state_nx = hpe_pkg::ST_LOAD;
			end
			default: state_nx = hpe_pkg::ST_LOAD;
		endcase
	end

	always_comb begin
		mem_we    = 1'b0;
		mem_re    = 1'b0;
		mem_addr  = '0;
		mem_wdata = item.element;
		busy      = 1'b1;
		unique case (state_q)
			hpe_pkg::ST_LOAD: begin
				busy     = 1'b0;
				mem_we   = accept && room;
				mem_addr = cnt_q[AW-1:0];
			end
			hpe_pkg::ST_PIV_RD: begin
				mem_re = 1'b1;
			end
			hpe_pkg::ST_PIV: begin
				mem_re   = 1'b1;
				mem_addr = right_q;
			end
			hpe_pkg::ST_LEFT_RD: begin
				mem_re   = 1'b1;
				mem_addr = left_q;
			end
			hpe_pkg::ST_LEFT: begin
				mem_re   = 1'b1;
				mem_addr = left_go ? left_q + AW'(1) : right_q;
			end
			hpe_pkg::ST_RIGHT: begin
				priority if (right_go) begin
					mem_re   = 1'b1;
					mem_addr = right_q - AW'(1);
				end else if (!crossed) begin
					mem_we    = 1'b1;
					mem_addr  = left_q;
					mem_wdata = rdata;
				end
			end
			hpe_pkg::ST_SWAP: begin
				mem_we    = 1'b1;
				mem_addr  = right_q;
				mem_wdata = lval_q;
			end
			hpe_pkg::ST_EMIT: begin
				mem_re   = 1'b1;
				mem_addr = pos_q;
			end
			default: begin
				busy = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= hpe_pkg::ST_LOAD;
			cnt_q    <= '0;
			ovf_q    <= 1'b0;
			left_q   <= '0;
			right_q  <= '0;
			pos_q    <= '0;
			valid_s1 <= 1'b0;
		end else begin
			state_q  <= state_nx;
			valid_s1 <= state_q == hpe_pkg::ST_EMIT;
			unique case (state_q)
				hpe_pkg::ST_LOAD: begin
					if (accept) begin
						cnt_q <= cnt_nx;
						if (!room) ovf_q <= 1'b1;
						if (item.is_last) begin
							left_q  <= '0;
							right_q <= AW'(cnt_nx - CW'(1));
						end
					end
				end
				hpe_pkg::ST_LEFT: begin
					if (left_go) left_q <= left_q + AW'(1);
				end
				hpe_pkg::ST_RIGHT: begin
					priority if (right_go) right_q <= right_q - AW'(1);
					else if (crossed)      pos_q   <= '0;
				end
				hpe_pkg::ST_SWAP: begin
					left_q  <= left_q + AW'(1);
					right_q <= right_q - AW'(1);
				end
				hpe_pkg::ST_EMIT: begin
					pos_q <= pos_q + AW'(1);
					if (emit_last) begin
						cnt_q <= '0;
						ovf_q <= 1'b0;
					end
				end
				default: begin
					pos_q <= pos_q;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		pos_s1  <= pos_q;
		last_s1 <= emit_last;
		ovf_s1  <= ovf_q;
		if (state_q == hpe_pkg::ST_PIV) begin
			pivot_q <= rdata;
			lval_q  <= rdata;
		end
		if (state_q == hpe_pkg::ST_LEFT && !left_go) begin
			lval_q <= rdata;
		end
		if (state_q == hpe_pkg::ST_RIGHT && !right_go && crossed) begin
			split_q <= right_q;
		end
	end

	assign strobe             = valid_s1;
	assign result.out_element = rdata;
	assign result.position    = hpe_pkg::POS_W'(pos_s1);
	assign result.split_index = hpe_pkg::POS_W'(split_q);
	assign result.overflow    = ovf_s1;
	assign result.last_out    = last_s1;

	a_port_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(mem_we && mem_re))
		else $error("memory write and read in the same cycle");

	a_busy_run: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && !result.last_out) |-> busy)
		else $error("engine idle in the middle of a result run");

	a_run_end: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && result.last_out) |=> !strobe)
		else $error("result issued after the final one of a run");

	a_run_start: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(strobe) |-> (result.position == '0))
		else $error("result run does not start at position zero");

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(DEPTH))
		else $error("fill count beyond buffer depth");

endmodule

`default_nettype wire

### dv/hoare_partition_engine_test.sv
`default_nettype none

module hoare_partition_engine_test;
	timeunit 1ns;
	timeprecision 1ps;

	import hpe_pkg::*;

	localparam int unsigned DEPTH          = 64;
	localparam int          CLK_HALF       = 10;
	localparam int unsigned RANDOM_ITEMS   = 360;
	localparam int unsigned DIRECTED_ROWS  = 25;
	localparam int unsigned DRAIN_CYCLES   = 50;
	localparam int unsigned TIMEOUT_CYCLES = 200_000;

	localparam logic signed [ELEM_W-1:0] ELEM_MIN = 32'sh8000_0000;
	localparam logic signed [ELEM_W-1:0] ELEM_MAX = 32'sh7fff_ffff;

	typedef struct {
		in_item_t stim;
		bit       has_exp;
		result_t  exp_result;
	} dir_row_t;

	logic     clk = 1'b0;
	logic     arst_n;
	logic     start;
	logic     busy;
	in_item_t item;
	logic     strobe;
	result_t  result;

	logic signed [ELEM_W-1:0] shadow_store [DEPTH];
	int unsigned              shadow_count = 0;
	logic                     shadow_overflow = 1'b0;

	result_t     expected_results [$];
	int unsigned mismatch_count = 0;

	dir_row_t directed_rows [DIRECTED_ROWS] = '{
		'{'{ELEM_MIN, 1'b1}, 1'b1, '{ELEM_MIN, 6'd0, 6'd0, 1'b0, 1'b1}},
		'{'{ELEM_MAX, 1'b1}, 1'b1, '{ELEM_MAX, 6'd0, 6'd0, 1'b0, 1'b1}},
		'{'{32'sd0, 1'b1}, 1'b1, '{32'sd0, 6'd0, 6'd0, 1'b0, 1'b1}},
		'{'{-32'sd1, 1'b1}, 1'b1, '{-32'sd1, 6'd0, 6'd0, 1'b0, 1'b1}},
		'{'{32'sd5, 1'b0}, 1'b0, '0},
		'{'{32'sd3, 1'b1}, 1'b0, '0},
		'{'{32'sd7, 1'b0}, 1'b0, '0},
		'{'{32'sd7, 1'b1}, 1'b0, '0},
		'{'{ELEM_MIN, 1'b0}, 1'b0, '0},
		'{'{ELEM_MAX, 1'b0}, 1'b0, '0},
		'{'{32'sd0, 1'b1}, 1'b0, '0},
		'{'{ELEM_MAX, 1'b0}, 1'b0, '0},
		'{'{ELEM_MIN, 1'b0}, 1'b0, '0},
		'{'{-32'sd1, 1'b1}, 1'b0, '0},
		'{'{32'sd3, 1'b0}, 1'b0, '0},
		'{'{32'sd1, 1'b0}, 1'b0, '0},
		'{'{32'sd4, 1'b0}, 1'b0, '0},
		'{'{32'sd1, 1'b0}, 1'b0, '0},
		'{'{32'sd5, 1'b1}, 1'b0, '0},
		'{'{-32'sd5, 1'b0}, 1'b0, '0},
		'{'{-32'sd5, 1'b0}, 1'b0, '0},
		'{'{-32'sd5, 1'b0}, 1'b0, '0},
		'{'{-32'sd5, 1'b1}, 1'b0, '0},
		'{'{32'sd2, 1'b0}, 1'b0, '0},
		'{'{-32'sd2, 1'b1}, 1'b0, '0}
	};

	hoare_partition_engine #(
		.DEPTH(DEPTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.item(item),
		.strobe(strobe),
		.result(result)
	);

	always #CLK_HALF clk = ~clk;

	function automatic void predict_partition(input in_item_t it, output result_t outs [$]);
		int                       n;
		int                       lp;
		int                       rp;
		logic signed [ELEM_W-1:0] pivot;
		logic signed [ELEM_W-1:0] held;
		result_t                  r;
		outs = {};
		if (shadow_count < DEPTH) begin
			shadow_store[shadow_count] = it.element;
			shadow_count++;
		end else begin
			shadow_overflow = 1'b1;
		end
		if (!it.is_last)
			return;
		n = shadow_count;
		pivot = shadow_store[0];
		lp = -1;
		rp = n;
		while (1) begin
			do lp++; while (lp < n - 1 && shadow_store[lp] < pivot);
			do rp--; while (rp > 0 && shadow_store[rp] > pivot);
			if (lp >= rp)
				break;
			held = shadow_store[lp];
			shadow_store[lp] = shadow_store[rp];
			shadow_store[rp] = held;
		end
		for (int k = 0; k < n; k++) begin
			r.out_element = shadow_store[k];
			r.position    = POS_W'(k);
			r.split_index = POS_W'(rp);
			r.overflow    = shadow_overflow;
			r.last_out    = (k == n - 1);
			outs.push_back(r);
		end
		shadow_count = 0;
		shadow_overflow = 1'b0;
	endfunction

	function automatic logic signed [ELEM_W-1:0] draw_element();
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4: return $urandom;
			5, 6, 7: return $urandom_range(0, 15) - 8;
			8: return $urandom_range(0, 1) ? ELEM_MIN : ELEM_MAX;
			default: return $urandom_range(0, 2) - 1;
		endcase
	endfunction

	task automatic send_element(input in_item_t it, input bit has_exp, input result_t exp_r,
		input int unsigned gap);
		result_t predicted [$];
		if (gap != 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		item <= it;
		do @(posedge clk); while (busy);
		predict_partition(it, predicted);
		if (has_exp)
			expected_results.push_back(exp_r);
		else
			foreach (predicted[i]) expected_results.push_back(predicted[i]);
	endtask

	always @(posedge clk) begin
		result_t want;
		if (arst_n && strobe) begin
			if (expected_results.size() == 0) begin
				$error("unexpected result transaction: out_element %0d position %0d",
					result.out_element, result.position);
				mismatch_count++;
			end else begin
				want = expected_results.pop_front();
				if (result.out_element !== want.out_element) begin
					$error("out_element: expected %0d, actual %0d", want.out_element,
						result.out_element);
					mismatch_count++;
				end
				if (result.position !== want.position) begin
					$error("position: expected %0d, actual %0d", want.position, result.position);
					mismatch_count++;
				end
				if (result.split_index !== want.split_index) begin
					$error("split_index: expected %0d, actual %0d", want.split_index,
						result.split_index);
					mismatch_count++;
				end
				if (result.overflow !== want.overflow) begin
					$error("overflow: expected %0d, actual %0d", want.overflow, result.overflow);
					mismatch_count++;
				end
				if (result.last_out !== want.last_out) begin
					$error("last_out: expected %0d, actual %0d", want.last_out, result.last_out);
					mismatch_count++;
				end
			end
		end
	end

	initial begin
		int unsigned items_sent;
		int unsigned set_index;
		int unsigned set_len;
		int unsigned sel;
		bit          burst;
		in_item_t    stim_item;
		arst_n = 1'b0;
		start = 1'b0;
		item = '0;
		items_sent = 0;
		set_index = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (directed_rows[i])
			send_element(directed_rows[i].stim, directed_rows[i].has_exp,
				directed_rows[i].exp_result,
				$urandom_range(0, 1) ? 0 : $urandom_range(0, 19));
		while (items_sent < RANDOM_ITEMS) begin
			case (set_index)
				0: set_len = DEPTH;
				1: set_len = DEPTH + 1;
				default: begin
					sel = $urandom_range(0, 99);
					if (sel < 80)
						set_len = $urandom_range(1, 8);
					else if (sel < 93)
						set_len = $urandom_range(9, DEPTH);
					else
						set_len = $urandom_range(DEPTH + 1, DEPTH + 4);
				end
			endcase
			burst = ($urandom_range(0, 3) == 0);
			for (int k = 0; k < set_len; k++) begin
				stim_item.element = draw_element();
				stim_item.is_last = (k == set_len - 1);
				send_element(stim_item, 1'b0, '0, burst ? 0 : $urandom_range(0, 19));
				items_sent++;
			end
			set_index++;
		end
		start <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	initial begin
		#(TIMEOUT_CYCLES * 2 * CLK_HALF);
		$display("timeout with %0d result transactions outstanding", expected_results.size());
		$display("*** FAILED ***");
		$finish;
	end

endmodule

`default_nettype wire

### files.f
rtl/core/hpe_pkg.sv
rtl/core/hpe_store.sv
rtl/core/hoare_partition_engine.sv
dv/hoare_partition_engine_test.sv
